@@ rtl/core/bpge_pkg.sv @@
// bpge_pkg: types, gate codes and truth-table helpers for the gate evaluator
// no dependencies; used by every other file in rtl/core

package bpge_pkg;

  localparam int WORD_W = 64;
  localparam int FUNC_W = 7;
  localparam int PINS   = 5;
  localparam int TT_W   = 2 ** PINS;

  typedef enum logic [FUNC_W-1:0] {
    G_INV = 7'd0, G_BUF, G_INPUT, G_WBR_IN, G_WBR_OUT,
    G_AND2, G_AND2B, G_AND3, G_AND4, G_OR2, G_OR3, G_OR4,
    G_NAND2, G_NAND3, G_NAND4, G_NOR2, G_NOR3, G_NOR4,
    G_XOR2, G_XOR3, G_XNOR2, G_XNOR3,
    G_OAI21, G_AOI21, G_OAI22, G_AOI22,
    G_MUX2I, G_MUX2,
    G_A21O, G_A21OI, G_A21BO, G_A21BOI, G_A22O, G_A22OI,
    G_A211OI, G_A2111OI, G_A221O, G_A221OI, G_A31O, G_A31OI,
    G_A32O, G_A32OI, G_A41OI,
    G_O21A, G_O21AI, G_O21BAI, G_O22A, G_O22AI, G_O211AI,
    G_O221AI, G_O31A, G_O31AI, G_O311A, G_O311AI, G_O32AI,
    G_NAND2B, G_NAND3B, G_NAND4B, G_NOR2B, G_NOR3B, G_NOR4B,
    G_OR3B, G_OR4B,
    G_CONST0, G_CONST1,
    G_FA_SUM, G_FA_CARRY, G_HA_SUM, G_HA_CARRY
  } gate_func_t;

  localparam gate_func_t GATE_LAST = G_HA_CARRY;

  // truth table of the selected cell, indexed by {e,d,c,b,a}
  typedef struct packed {
    logic [TT_W-1:0] tt;
    logic            bad;
  } decode_t;

  function automatic logic gate_bit(input gate_func_t f, input logic a, input logic b,
                                    input logic c, input logic d, input logic e);
    logic r;
    r = 1'b0;
    unique case (f)
      G_INV:      r = ~a;
      G_BUF, G_INPUT, G_WBR_IN, G_WBR_OUT: r = a;
      G_AND2:     r = a & b;
      G_AND2B:    r = a & ~b;
      G_AND3:     r = a & b & c;
      G_AND4:     r = a & b & c & d;
      G_OR2:      r = a | b;
      G_OR3:      r = a | b | c;
      G_OR4:      r = a | b | c | d;
      G_NAND2:    r = ~(a & b);
      G_NAND3:    r = ~(a & b & c);
      G_NAND4:    r = ~(a & b & c & d);
      G_NOR2:     r = ~(a | b);
      G_NOR3:     r = ~(a | b | c);
      G_NOR4:     r = ~(a | b | c | d);
      G_XOR2:     r = a ^ b;
      G_XOR3:     r = a ^ b ^ c;
      G_XNOR2:    r = ~(a ^ b);
      G_XNOR3:    r = ~(a ^ b ^ c);
      G_OAI21:    r = ~((a | b) & c);
      G_AOI21:    r = ~((a & b) | c);
      G_OAI22:    r = ~((a | b) & (c | d));
      G_AOI22:    r = ~((a & b) | (c & d));
      G_MUX2I:    r = ~((c & a) | (~c & b));
      G_MUX2:     r = (~c & a) | (c & b);
      G_A21O:     r = (a & b) | c;
      G_A21OI:    r = ~((a & b) | c);
      G_A21BO:    r = (a & b) | ~c;
      G_A21BOI:   r = ~((a & b) | ~c);
      G_A22O:     r = (a & b) | (c & d);
      G_A22OI:    r = ~((a & b) | (c & d));
      G_A211OI:   r = ~((a & b) | c | d);
      G_A2111OI:  r = ~((a & b) | c | d | e);
      G_A221O:    r = (a & b) | (c & d) | e;
      G_A221OI:   r = ~((a & b) | (c & d) | e);
      G_A31O:     r = (a & b & c) | d;
      G_A31OI:    r = ~((a & b & c) | d);
      G_A32O:     r = (a & b & c) | (d & e);
      G_A32OI:    r = ~((a & b & c) | (d & e));
      G_A41OI:    r = ~((a & b & c & d) | e);
      G_O21A:     r = (a | b) & c;
      G_O21AI:    r = ~((a | b) & c);
      G_O21BAI:   r = ~((a | b) & ~c);
      G_O22A:     r = (a | b) & (c | d);
      G_O22AI:    r = ~((a | b) & (c | d));
      G_O211AI:   r = ~((a | b) & c & d);
      G_O221AI:   r = ~((a | b) & (c | d) & e);
      G_O31A:     r = (a | b | c) & d;
      G_O31AI:    r = ~((a | b | c) & d);
      G_O311A:    r = (a | b | c) & d & e;
      G_O311AI:   r = ~((a | b | c) & d & e);
      G_O32AI:    r = ~((a | b | c) & (d | e));
      G_NAND2B:   r = a | ~b;
      G_NAND3B:   r = a | ~b | ~c;
      G_NAND4B:   r = a | ~b | ~c | ~d;
      G_NOR2B:    r = ~a & b;
      G_NOR3B:    r = ~a & ~b & c;
      G_NOR4B:    r = ~a & ~b & ~c & d;
      G_OR3B:     r = a | b | ~c;
      G_OR4B:     r = a | b | c | ~d;
      G_CONST0:   r = 1'b0;
      G_CONST1:   r = 1'b1;
      G_FA_SUM:   r = a ^ b ^ c;
      G_FA_CARRY: r = (a & b) | (b & c) | (a & c);
      G_HA_SUM:   r = a ^ b;
      G_HA_CARRY: r = a & b;
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

  // expand a cell into its 32-entry truth table; unknown codes give all zero
  function automatic logic [TT_W-1:0] gate_table(input gate_func_t f);
    logic [TT_W-1:0] t;
    logic [PINS-1:0] idx;
    t = '0;
    for (int i = 0; i < TT_W; i++) begin
      idx  = PINS'(i);
      t[i] = gate_bit(f, idx[0], idx[1], idx[2], idx[3], idx[4]);
    end
    return t;
  endfunction

endpackage

@@ rtl/core/bpge_if.sv @@
// bpge_req_if / bpge_rsp_if: valid/ready channels of the gate evaluator
// depends on bpge_pkg for field widths

interface bpge_req_if;
  logic                            valid;
  logic                            ready;
  logic [bpge_pkg::FUNC_W-1:0]     func;
  logic [bpge_pkg::WORD_W-1:0]     pin_a;
  logic [bpge_pkg::WORD_W-1:0]     pin_b;
  logic [bpge_pkg::WORD_W-1:0]     pin_c;
  logic [bpge_pkg::WORD_W-1:0]     pin_d;
  logic [bpge_pkg::WORD_W-1:0]     pin_e;

  modport source (output valid, func, pin_a, pin_b, pin_c, pin_d, pin_e, input ready);
  modport sink   (input valid, func, pin_a, pin_b, pin_c, pin_d, pin_e, output ready);
endinterface

interface bpge_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [bpge_pkg::WORD_W-1:0]     out_word;
  logic                            bad_type;

  modport source (output valid, out_word, bad_type, input ready);
  modport sink   (input valid, out_word, bad_type, output ready);
endinterface

@@ rtl/core/bpge_decode.sv @@
// bpge_decode: turns the gate code into a truth table shared by all lanes
// depends on bpge_pkg

module bpge_decode (
  input  logic [bpge_pkg::FUNC_W-1:0] func,
  output bpge_pkg::decode_t           dec
);

  bpge_pkg::gate_func_t code;

  assign code    = bpge_pkg::gate_func_t'(func);
  assign dec.bad = (func > bpge_pkg::GATE_LAST);
  assign dec.tt  = bpge_pkg::gate_table(code);

endmodule

@@ rtl/core/bpge_lane.sv @@
// bpge_lane: evaluates the selected cell for one test pattern (one bit position)
// depends on bpge_pkg

module bpge_lane (
  input  bpge_pkg::decode_t dec,
  input  logic              a,
  input  logic              b,
  input  logic              c,
  input  logic              d,
  input  logic              e,
  output logic              y
);

  logic [bpge_pkg::PINS-1:0] sel;

  // pin values pick the truth-table entry
  assign sel = {e, d, c, b, a};
  assign y   = dec.tt[sel];

endmodule

@@ rtl/core/bpge_merge.sv @@
// bpge_merge: collects lane bits and the error flag into a two-entry result buffer
// depends on bpge_pkg and bpge_rsp_if

module bpge_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        push_ready,
  input  logic [bpge_pkg::WORD_W-1:0] word,
  input  logic                        bad,
  bpge_rsp_if.source                  rsp
);

  logic [bpge_pkg::WORD_W-1:0] buf_word [2];
  logic                        buf_bad  [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  count;
  logic                        pop;

  assign push_ready   = (count != 2'd2);
  assign pop          = rsp.valid && rsp.ready;
  assign rsp.valid    = (count != 2'd0);
  assign rsp.out_word = buf_word[rd_ptr];
  assign rsp.bad_type = buf_bad[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_word[wr_ptr] <= bad ? '0 : word;
      buf_bad[wr_ptr]  <= bad;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("result buffer count out of range");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 && push) |=> rsp.valid) else $error("pushed result not presented");

  a_hold_count: assert property (@(posedge clk) disable iff (rst)
    (!push && !pop) |=> $stable(count)) else $error("count moved without transaction");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.bad_type) |-> (rsp.out_word == '0))
    else $error("unsupported code gave nonzero word");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 2'd1))
    else $error("pop did not drain buffer");

endmodule

@@ rtl/core/bit_parallel_gate_evaluator_top.sv @@
// bit_parallel_gate_evaluator_top: bit-parallel standard-cell gate evaluator
// results: each result is registered in the result buffer and presented in request order
// throughput: one transaction per cycle unless the result buffer is full; the
//   two-entry buffer keeps requests open while one finished result waits on rsp
// reset: rst is synchronous, active high, and empties the result buffer
// depends on bpge_pkg, bpge_if, bpge_decode, bpge_lane, bpge_merge

module bit_parallel_gate_evaluator_top #(
  parameter int LANES = 64
) (
  input  logic       clk,
  input  logic       rst,
  bpge_req_if.sink   req,
  bpge_rsp_if.source rsp
);

  bpge_pkg::decode_t           dec;
  logic [bpge_pkg::WORD_W-1:0] lane_word;
  logic                        push;
  logic                        push_ready;

  // one decoder for the whole word; the truth table fans out to every lane
  bpge_decode u_decode (
    .func (req.func),
    .dec  (dec)
  );

  // one lane per evaluated pattern; positions at and above LANES read zero
  for (genvar l = 0; l < bpge_pkg::WORD_W; l++) begin : g_lane
    if (l < LANES) begin : g_on
      bpge_lane u_lane (
        .dec (dec),
        .a   (req.pin_a[l]),
        .b   (req.pin_b[l]),
        .c   (req.pin_c[l]),
        .d   (req.pin_d[l]),
        .e   (req.pin_e[l]),
        .y   (lane_word[l])
      );
    end else begin : g_off
      assign lane_word[l] = 1'b0;
    end
  end

  // request transaction accepted whenever the result buffer has room
  assign req.ready = push_ready;
  assign push      = req.valid && push_ready;

  // merge stage: gathers lane bits and error flag into the result buffer
  bpge_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .word       (lane_word),
    .bad        (dec.bad),
    .rsp        (rsp)
  );

endmodule
